// ===== rtl/kct_pkg.sv =====
`default_nettype none
package kct_pkg;

	localparam int KCT_ENTRIES    = 16;
	localparam int KCT_KEY_BITS   = 8;
	localparam int KCT_COUNT_BITS = 16;

	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_CONSUME = 2'd1,
		REQ_QUERY   = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_DONE     = 3'd0,
		STS_INVALID  = 3'd1,
		STS_FULL     = 3'd2,
		STS_SHORT    = 3'd3,
		STS_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CK_NONE  = 2'd0,
		CK_SET   = 2'd1,
		CK_CLAIM = 2'd2,
		CK_CLEAR = 2'd3
	} commit_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SEARCH = 2'd1,
		S_COMMIT = 2'd2,
		S_RESULT = 2'd3
	} fsm_t;

	// token control that walks the cell chain
	// claimed: search pass = free cell seen, commit pass = free cell taken
	typedef struct packed {
		logic    vld;
		logic    commit;
		commit_t kind;
		logic    found;
		logic    claimed;
	} tok_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/kct_cell.sv =====
`default_nettype none
module kct_cell import kct_pkg::*; #(
	parameter int KEY_BITS   = KCT_KEY_BITS,
	parameter int COUNT_BITS = KCT_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tok_ctl_t              prev_ctl,
	input  wire logic [KEY_BITS-1:0]   prev_key,
	input  wire logic [COUNT_BITS-1:0] prev_cnt,
	output tok_ctl_t                   next_ctl,
	output logic [KEY_BITS-1:0]        next_key,
	output logic [COUNT_BITS-1:0]      next_cnt
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] cnt_q;
	tok_ctl_t              ctl_q;
	logic [KEY_BITS-1:0]   tkey_q;
	logic [COUNT_BITS-1:0] tcnt_q;

	logic                  match;
	logic                  take;
	logic                  set;
	logic                  clr;
	logic                  valid_d;
	tok_ctl_t              ctl_d;
	logic [COUNT_BITS-1:0] cnt_d;

	always_comb begin
		match = valid_q && (key_q == prev_key) && (prev_key != '0);
		take  = prev_ctl.vld && prev_ctl.commit && (prev_ctl.kind == CK_CLAIM)
			&& !prev_ctl.claimed && !valid_q;
		set   = prev_ctl.vld && prev_ctl.commit && (prev_ctl.kind == CK_SET) && match;
		clr   = prev_ctl.vld && prev_ctl.commit && (prev_ctl.kind == CK_CLEAR);

		ctl_d = prev_ctl;
		if (!prev_ctl.commit) begin
			ctl_d.found   = prev_ctl.found | match;
			ctl_d.claimed = prev_ctl.claimed | !valid_q;
		end else if (take) begin
			ctl_d.claimed = 1'b1;
		end
		cnt_d = (!prev_ctl.commit && match) ? cnt_q : prev_cnt;

		priority if (clr) begin
			valid_d = 1'b0;
		end else if (take) begin
			valid_d = 1'b1;
		end else if (set && (prev_cnt == '0)) begin
			valid_d = 1'b0;
		end else begin
			valid_d = valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_q   <= '0;
		end else begin
			valid_q <= valid_d;
			ctl_q   <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= prev_key;
		end
		if (take || set) begin
			cnt_q <= prev_cnt;
		end
		tkey_q <= prev_key;
		tcnt_q <= cnt_d;
	end

	assign next_ctl = ctl_q;
	assign next_key = tkey_q;
	assign next_cnt = tcnt_q;

endmodule
`default_nettype wire

// ===== rtl/keyed_count_table_top.sv =====
// Channel  | Handshake             | Payload
// request  | in_valid / in_ready   | req_type, item_key, amount
// result   | out_valid / out_ready | status, enough, held_count
//
// One item at a time; from accept to result a search token and then a commit
// token each walk the cell chain before the result state loads the output.
// A waiting result sits in the output register while the next item is taken.
// Reset empties the table at once; no clearing pass.
// Output stalls hold the block in the result state until the register frees.
`default_nettype none
module keyed_count_table_top import kct_pkg::*; #(
	parameter int ENTRIES    = KCT_ENTRIES,
	parameter int KEY_BITS   = KCT_KEY_BITS,
	parameter int COUNT_BITS = KCT_COUNT_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  item_key,
	input  wire logic [15:0] amount,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic             enough,
	output logic [15:0]      held_count
);

	localparam int W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	tok_ctl_t              ctl_c [0:ENTRIES];
	logic [KEY_BITS-1:0]   key_c [0:ENTRIES];
	logic [COUNT_BITS-1:0] cnt_c [0:ENTRIES];

	fsm_t                  state_q;
	fsm_t                  state_d;
	tok_ctl_t              inj_ctl_q;
	logic [KEY_BITS-1:0]   inj_key_q;
	logic [COUNT_BITS-1:0] inj_cnt_q;

	req_t                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [15:0]           amt_q;
	status_t               res_status_q;
	logic                  res_enough_q;
	logic [15:0]           res_held_q;

	logic                  out_vld_q;
	status_t               out_status_q;
	logic                  out_enough_q;
	logic [15:0]           out_held_q;

	logic                  accept;
	logic                  search_done;
	logic                  commit_done;
	logic                  load_out;

	logic                  trivial;
	logic [W-1:0]          held_w;
	logic [W-1:0]          amt_w;
	logic [W-1:0]          sum_w;
	logic [W-1:0]          res_w;
	logic                  covers;
	status_t               dec_status;
	commit_t               dec_kind;
	logic                  dec_enough;

	assign ctl_c[0] = inj_ctl_q;
	assign key_c[0] = inj_key_q;
	assign cnt_c[0] = inj_cnt_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kct_cell #(
			.KEY_BITS   (KEY_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_ctl (ctl_c[i]),
			.prev_key (key_c[i]),
			.prev_cnt (cnt_c[i]),
			.next_ctl (ctl_c[i+1]),
			.next_key (key_c[i+1]),
			.next_cnt (cnt_c[i+1])
		);
	end

	assign search_done = ctl_c[ENTRIES].vld && !ctl_c[ENTRIES].commit;
	assign commit_done = ctl_c[ENTRIES].vld && ctl_c[ENTRIES].commit;

	// decision at the chain end of the search pass
	always_comb begin
		trivial    = (key_q == '0) || (amt_q == '0);
		held_w     = W'(cnt_c[ENTRIES]);
		amt_w      = W'(amt_q);
		sum_w      = held_w + amt_w;
		covers     = held_w >= amt_w;
		res_w      = held_w;
		dec_status = STS_DONE;
		dec_kind   = CK_NONE;
		unique case (op_q)
			REQ_ADD: begin
				if (trivial) begin
					dec_status = STS_INVALID;
				end else if (ctl_c[ENTRIES].found) begin
					if (sum_w[W-1:COUNT_BITS] != '0) begin
						dec_status = STS_OVERFLOW;
					end else begin
						res_w    = sum_w;
						dec_kind = CK_SET;
					end
				end else if (!ctl_c[ENTRIES].claimed) begin
					dec_status = STS_FULL;
				end else if (amt_w[W-1:COUNT_BITS] != '0) begin
					dec_status = STS_OVERFLOW;
				end else begin
					res_w    = amt_w;
					dec_kind = CK_CLAIM;
				end
				dec_enough = trivial || (res_w >= amt_w);
			end
			REQ_CONSUME: begin
				if (trivial) begin
					dec_enough = 1'b1;
				end else if (!covers) begin
					dec_status = STS_SHORT;
					dec_enough = 1'b0;
				end else begin
					dec_enough = 1'b1;
					res_w      = held_w - amt_w;
					dec_kind   = CK_SET;
				end
			end
			REQ_QUERY: begin
				dec_enough = trivial || covers;
			end
			REQ_CLEAR: begin
				res_w      = '0;
				dec_kind   = CK_CLEAR;
				dec_enough = trivial;
			end
			default: begin
				dec_enough = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_d = S_SEARCH;
			S_SEARCH: if (search_done) state_d = S_COMMIT;
			S_COMMIT: if (commit_done) state_d = S_RESULT;
			S_RESULT: if (load_out) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		accept   = in_valid && in_ready;
		load_out = (state_q == S_RESULT) && (!out_vld_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			inj_ctl_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				inj_ctl_q <= '{vld: 1'b1, commit: 1'b0, kind: CK_NONE,
					found: 1'b0, claimed: 1'b0};
			end else if ((state_q == S_SEARCH) && search_done) begin
				inj_ctl_q <= '{vld: 1'b1, commit: 1'b1, kind: dec_kind,
					found: 1'b0, claimed: 1'b0};
			end else begin
				inj_ctl_q <= '0;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req_t'(req_type);
			key_q     <= KEY_BITS'(item_key);
			amt_q     <= amount;
			inj_key_q <= KEY_BITS'(item_key);
			inj_cnt_q <= '0;
		end else if ((state_q == S_SEARCH) && search_done) begin
			inj_cnt_q    <= res_w[COUNT_BITS-1:0];
			res_status_q <= dec_status;
			res_enough_q <= dec_enough;
			res_held_q   <= res_w[15:0];
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_enough_q <= res_enough_q;
			out_held_q   <= res_held_q;
		end
	end

	assign out_valid  = out_vld_q;
	assign status     = out_status_q;
	assign enough     = out_enough_q;
	assign held_count = out_held_q;

endmodule
`default_nettype wire

// ===== rtl/kct_checker.sv =====
`default_nettype none
module kct_checker import kct_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic        enough,
	input wire logic [15:0] held_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(enough) && $stable(held_count))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= STS_OVERFLOW))
		else $error("status code out of range");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_SHORT) |-> !enough)
		else $error("short consume reported as covered");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_INVALID) |-> enough)
		else $error("invalid add without enough flag");

endmodule

bind keyed_count_table_top kct_checker u_kct_checker (.*);
`default_nettype wire

// ===== dv/keyed_count_table_checker.sv =====
`timescale 1ns / 1ps
module keyed_count_table_checker import kct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  item_key,
	input  logic [15:0] amount,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic        enough,
	input  logic [15:0] held_count,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output logic [4:0]  status_seen
);

	typedef struct {
		status_t     sts;
		logic        en;
		logic [15:0] cnt;
	} count_result_t;

	logic                      slot_used [KCT_ENTRIES];
	logic [KCT_KEY_BITS-1:0]   slot_key  [KCT_ENTRIES];
	logic [KCT_COUNT_BITS-1:0] slot_cnt  [KCT_ENTRIES];

	count_result_t expected_results [$];
	int mismatches = 0;
	int n_checked = 0;

	function automatic count_result_t apply_request(input req_t op, input logic [7:0] key_in,
			input logic [15:0] amt);
		count_result_t r;
		logic [KCT_KEY_BITS-1:0] key;
		logic triv;
		int hit;
		int free_slot;
		logic [KCT_COUNT_BITS:0] sum;
		logic [KCT_COUNT_BITS-1:0] held;
		key  = key_in[KCT_KEY_BITS-1:0];
		triv = (key == 0) || (amt == 0);
		hit  = -1;
		if (key != 0)
			for (int i = 0; i < KCT_ENTRIES; i++)
				if (hit < 0 && slot_used[i] && slot_key[i] == key)
					hit = i;
		held  = (hit >= 0) ? slot_cnt[hit] : '0;
		r.sts = STS_DONE;
		case (op)
			REQ_ADD: begin
				if (triv) begin
					r.sts = STS_INVALID;
				end else if (hit >= 0) begin
					sum = {1'b0, held} + amt;
					if (sum[KCT_COUNT_BITS]) begin
						r.sts = STS_OVERFLOW;
					end else begin
						held = sum[KCT_COUNT_BITS-1:0];
						slot_cnt[hit] = held;
					end
				end else begin
					free_slot = -1;
					for (int i = 0; i < KCT_ENTRIES; i++)
						if (free_slot < 0 && !slot_used[i])
							free_slot = i;
					if (free_slot < 0) begin
						r.sts = STS_FULL;
					end else begin
						slot_used[free_slot] = 1'b1;
						slot_key[free_slot]  = key;
						slot_cnt[free_slot]  = amt;
						held = amt;
					end
				end
				r.en = triv || (held >= amt);
			end
			REQ_CONSUME: begin
				if (triv) begin
					r.en = 1'b1;
				end else if (held < amt) begin
					r.sts = STS_SHORT;
					r.en  = 1'b0;
				end else begin
					r.en = 1'b1;
					held = held - amt;
					slot_cnt[hit] = held;
					if (held == 0)
						slot_used[hit] = 1'b0;
				end
			end
			REQ_QUERY: begin
				r.en = triv || (held >= amt);
			end
			default: begin
				for (int i = 0; i < KCT_ENTRIES; i++)
					slot_used[i] = 1'b0;
				held = '0;
				r.en = triv;
			end
		endcase
		r.cnt = held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		count_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < KCT_ENTRIES; i++)
				slot_used[i] = 1'b0;
			expected_results.delete();
			status_seen <= '0;
		end else begin
			if (out_valid && out_ready) begin
				n_checked++;
				if (status <= STS_OVERFLOW)
					status_seen <= status_seen | (5'b1 << status);
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result status %0d enough %0d held_count %0d",
						$time, status, enough, held_count);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.sts) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d", $time, want.sts, status);
					end
					if (enough !== want.en) begin
						mismatches++;
						$display("%0t: enough expected %0d actual %0d", $time, want.en, enough);
					end
					if (held_count !== want.cnt) begin
						mismatches++;
						$display("%0t: held_count expected %0d actual %0d",
							$time, want.cnt, held_count);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					apply_request(req_t'(req_type), item_key, amount));
		end
		fail_count <= mismatches;
		pending    <= expected_results.size();
		checked    <= n_checked;
	end

endmodule

// ===== dv/tb_keyed_count_table_top.sv =====
`timescale 1ns / 1ps
module tb_keyed_count_table_top;
	import kct_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [7:0]  item_key;
	logic [15:0] amount;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic        enough;
	logic [15:0] held_count;

	int         fail_count;
	int         pending;
	int         checked;
	logic [4:0] status_seen;

	bit tx_fast = 1'b0;
	bit rx_fast = 1'b0;
	int rx_wait = 0;
	int idle_cycles = 0;
	int requests_sent = 0;
	int phases = 0;

	keyed_count_table_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.item_key   (item_key),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.enough     (enough),
		.held_count (held_count)
	);

	keyed_count_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.item_key    (item_key),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.enough      (enough),
		.held_count  (held_count),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.status_seen (status_seen)
	);

	always #10 clk = ~clk;

	// result side: random stall after each accepted result
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rx_wait = rx_fast ? 0 : $urandom_range(0, 11);
			if (rx_wait > 0)
				out_ready <= 1'b0;
		end else if (!out_ready && arst_n) begin
			if (rx_wait <= 1)
				out_ready <= 1'b1;
			rx_wait = rx_wait - 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_request(input req_t op, input logic [7:0] key, input logic [15:0] amt);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		item_key <= key;
		amount   <= amt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic random_request(input int key_base, input int pool, input int add_pct);
		int r;
		req_t op;
		logic [7:0] key;
		logic [15:0] amt;
		r = $urandom_range(0, 99);
		if (r < 2)
			op = REQ_CLEAR;
		else if (r < 2 + add_pct)
			op = REQ_ADD;
		else if (r < 2 + add_pct + (98 - add_pct) * 2 / 3)
			op = REQ_CONSUME;
		else
			op = REQ_QUERY;
		r = $urandom_range(0, 99);
		if (r < 5)
			key = 8'h00;
		else if (r < 15)
			key = 8'($urandom_range(0, 255));
		else
			key = 8'(key_base + $urandom_range(0, pool - 1));
		r = $urandom_range(0, 99);
		if (r < 4)
			amt = 16'h0000;
		else if (r < 45)
			amt = 16'($urandom_range(1, 4));
		else if (r < 65)
			amt = 16'($urandom_range(1, 300));
		else if (r < 80)
			amt = 16'($urandom_range(0, 16'hFFFF));
		else if (r < 90)
			amt = 16'($urandom_range(16'hFF00, 16'hFFFF));
		else
			amt = 16'($urandom_range(16'h8000, 16'hFFFF));
		send_request(op, key, amt);
	endtask

	initial begin : stimulus
		int pool;
		int key_base;
		int add_pct;
		int len;
		int n_random;
		arst_n   = 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_QUERY;
		item_key <= '0;
		amount   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refusals, count limits, trivial cases, clear
		send_request(REQ_ADD,     8'h00, 16'd5);
		send_request(REQ_ADD,     8'h05, 16'd0);
		send_request(REQ_ADD,     8'hFF, 16'hFFFF);
		send_request(REQ_ADD,     8'hFF, 16'd1);
		send_request(REQ_QUERY,   8'hFF, 16'hFFFF);
		send_request(REQ_CONSUME, 8'hFF, 16'hFFFF);
		send_request(REQ_CONSUME, 8'hFF, 16'd1);
		send_request(REQ_QUERY,   8'hFF, 16'd1);
		send_request(REQ_CONSUME, 8'h00, 16'd3);
		send_request(REQ_CONSUME, 8'h07, 16'd0);
		send_request(REQ_QUERY,   8'h00, 16'hFFFF);
		send_request(REQ_ADD,     8'h80, 16'h8000);
		send_request(REQ_ADD,     8'h80, 16'h8000);
		send_request(REQ_CLEAR,   8'h00, 16'd0);
		send_request(REQ_QUERY,   8'h80, 16'd1);
		send_request(REQ_CLEAR,   8'h03, 16'd2);
		wait_all_results();

		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: pool = 4;
				1: pool = 12;
				2: pool = 20;
				default: pool = 40;
			endcase
			case ($urandom_range(0, 2))
				0: add_pct = 35;
				1: add_pct = 50;
				default: add_pct = 70;
			endcase
			key_base = $urandom_range(1, 256 - pool);
			tx_fast  = ($urandom_range(0, 3) == 0);
			rx_fast  = ($urandom_range(0, 3) == 0);
			len      = $urandom_range(60, 200);
			if (len > RANDOM_ITEMS - n_random)
				len = RANDOM_ITEMS - n_random;
			repeat (len) begin
				random_request(key_base, pool, add_pct);
				n_random++;
			end
			phases++;
			wait_all_results();
		end

		tx_fast = 1'b0;
		rx_fast = 1'b0;
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d random phases), checked %0d results",
			requests_sent, phases, checked);
		$display("Status codes seen, overflow down to done: %b", status_seen);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
